@@ design/tqc_pkg.sv @@
// tqc_pkg: sizes, codes and shared types for the ticket queue with cancel.
// Used by the interfaces, the cell chain, the controller, the top level and the checker.
package tqc_pkg;

   localparam int DEPTH       = 16;
   localparam int TICKET_BITS = 16;
   localparam int PARTY_BITS  = 8;

   // Fixed widths of the word fields.
   localparam int CMD_W       = 2;
   localparam int PARTY_IN_W  = 8;
   localparam int POS_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int TICKET_W    = 16;
   localparam int PARTY_OUT_W = 8;
   localparam int OCC_W       = 5;

   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS   = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_CANCEL  = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NOPOS = 2'd3
   } status_type;

   typedef struct packed {
      logic                   valid;
      logic [TICKET_BITS-1:0] ticket;
      logic [PARTY_BITS-1:0]  party;
   } cell_data_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      status_type             status;
      logic [TICKET_W-1:0]    ticket;
      logic [PARTY_OUT_W-1:0] party_out;
      logic [OCC_W-1:0]       occupancy;
   } result_type;

endpackage

@@ design/tqc_ifs.sv @@
// tqc_ifs: valid/ready channel interfaces for command words and result words.
// Depends on tqc_pkg for field widths.
interface tqc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tqc_pkg::CMD_W-1:0]      command;
   logic [tqc_pkg::PARTY_IN_W-1:0] party_size;
   logic [tqc_pkg::POS_W-1:0]      position;

   modport source (output valid, command, party_size, position, input ready);
   modport sink   (input valid, command, party_size, position, output ready);
endinterface

interface tqc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tqc_pkg::STATUS_W-1:0]    status;
   logic [tqc_pkg::TICKET_W-1:0]    ticket;
   logic [tqc_pkg::PARTY_OUT_W-1:0] party_out;
   logic [tqc_pkg::OCC_W-1:0]       occupancy;

   modport source (output valid, status, ticket, party_out, occupancy, input ready);
   modport sink   (input valid, status, ticket, party_out, occupancy, output ready);
endinterface

@@ design/tqc_cell.sv @@
// tqc_cell: one queue slot; loads a new entry or takes its upper neighbor's entry.
// Depends on tqc_pkg for the cell data and control types.
module tqc_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  tqc_pkg::cell_ctl_type           ctl,
   input  logic [tqc_pkg::TICKET_BITS-1:0] load_ticket,
   input  logic [tqc_pkg::PARTY_BITS-1:0]  load_party,
   input  tqc_pkg::cell_data_type          next_data,
   output tqc_pkg::cell_data_type          cur_data
);

   logic                            valid_ff,  valid_in;
   logic [tqc_pkg::TICKET_BITS-1:0] ticket_ff, ticket_in;
   logic [tqc_pkg::PARTY_BITS-1:0]  party_ff,  party_in;

   always_comb begin
      valid_in  = valid_ff;
      ticket_in = ticket_ff;
      party_in  = party_ff;
      priority if (ctl.shift) begin
         // close up: take the neighbor toward the tail
         valid_in  = next_data.valid;
         ticket_in = next_data.ticket;
         party_in  = next_data.party;
      end else if (ctl.load) begin
         valid_in  = 1'b1;
         ticket_in = load_ticket;
         party_in  = load_party;
      end else begin
         // hold
         valid_in  = valid_ff;
         ticket_in = ticket_ff;
         party_in  = party_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ticket_ff <= ticket_in;
      party_ff  <= party_in;
   end

   assign cur_data = '{valid: valid_ff, ticket: ticket_ff, party: party_ff};

endmodule

@@ design/tqc_ctrl.sv @@
// tqc_ctrl: entry count, command decode, per-cell control and the result word.
// Depends on tqc_pkg; drives the cell chain in the top level.
module tqc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [tqc_pkg::CMD_W-1:0]       command,
   input  logic [tqc_pkg::PARTY_IN_W-1:0]  party_size,
   input  logic [tqc_pkg::POS_W-1:0]       position,
   input  tqc_pkg::cell_data_type          cells [tqc_pkg::DEPTH],
   output tqc_pkg::cell_ctl_type           ctl   [tqc_pkg::DEPTH],
   output logic [tqc_pkg::TICKET_BITS-1:0] load_ticket,
   output logic [tqc_pkg::PARTY_BITS-1:0]  load_party,
   output tqc_pkg::result_type             result
);

   logic [tqc_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                            full, empty, pos_ok;
   logic                            do_enq, do_rm;
   logic [tqc_pkg::IDX_BITS-1:0]    rm_idx, tail_idx;
   logic [tqc_pkg::TICKET_BITS-1:0] new_ticket, rd_ticket;
   logic [tqc_pkg::PARTY_BITS-1:0]  rd_party;
   tqc_pkg::cmd_type                cmd;
   tqc_pkg::status_type             status;

   assign cmd   = tqc_pkg::cmd_type'(command);
   assign full  = cells[tqc_pkg::DEPTH-1].valid;
   assign empty = !cells[0].valid;
   assign pos_ok = (position != '0) &&
                   (tqc_pkg::CMP_BITS'(position) <= tqc_pkg::CMP_BITS'(count_ff));

   assign tail_idx   = tqc_pkg::IDX_BITS'(count_ff - 1'b1);
   assign new_ticket = empty ? tqc_pkg::TICKET_BITS'(1)
                             : cells[tail_idx].ticket + 1'b1;
   assign load_ticket = new_ticket;
   assign load_party  = tqc_pkg::PARTY_BITS'(party_size);

   always_comb begin
      do_enq = 1'b0;
      do_rm  = 1'b0;
      rm_idx = '0;
      status = tqc_pkg::ST_OK;
      unique case (cmd)
         tqc_pkg::CMD_ENQUEUE: begin
            if (full) status = tqc_pkg::ST_FULL;
            else      do_enq = 1'b1;
         end
         tqc_pkg::CMD_DEQUEUE: begin
            if (empty) status = tqc_pkg::ST_EMPTY;
            else       do_rm  = 1'b1;
         end
         tqc_pkg::CMD_CANCEL: begin
            rm_idx = tqc_pkg::IDX_BITS'(position - 1'b1);
            if (pos_ok) do_rm  = 1'b1;
            else        status = tqc_pkg::ST_NOPOS;
         end
         default: ;
      endcase
   end

   assign rd_ticket = cells[rm_idx].ticket;
   assign rd_party  = cells[rm_idx].party;

   always_comb begin
      for (int i = 0; i < tqc_pkg::DEPTH; i++) begin
         ctl[i].load  = accept && do_enq &&
                        (count_ff == tqc_pkg::COUNT_BITS'(i));
         ctl[i].shift = accept && do_rm &&
                        (tqc_pkg::IDX_BITS'(i) >= rm_idx);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && do_enq) count_in = count_ff + 1'b1;
      if (accept && do_rm)  count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      result.status    = status;
      result.ticket    = '0;
      result.party_out = '0;
      result.occupancy = tqc_pkg::OCC_W'(count_in);
      if (do_enq) begin
         result.ticket    = tqc_pkg::TICKET_W'(new_ticket);
         result.party_out = tqc_pkg::PARTY_OUT_W'(load_party);
      end else if (do_rm) begin
         result.ticket    = tqc_pkg::TICKET_W'(rd_ticket);
         result.party_out = tqc_pkg::PARTY_OUT_W'(rd_party);
      end
   end

endmodule

@@ design/ticket_queue_with_cancel_top.sv @@
// ticket_queue_with_cancel_top: waiting queue built as a chain of slot cells.
// Depends on tqc_pkg, tqc_ifs, tqc_cell and tqc_ctrl.
//
//   channel  port    dir  fields
//   -------  ------  ---  ------------------------------------------
//   command  req_if  in   command, party_size, position
//   result   rsp_if  out  status, ticket, party_out, occupancy
//
// Cycles: one command word per cycle; its result word appears in the cycle
// after acceptance. The decode, the slot selects and the close-up of the cell
// chain all settle in the accept cycle, so the cell chain never holds up a word.
// Reset: synchronous; clears all slot valid bits, the entry count and the
// result valid bit. Stalls: req_if.ready drops only while a result word is
// held and rsp_if.ready is low.
module ticket_queue_with_cancel_top (
   input logic      clock,
   input logic      reset,
   tqc_req_if.sink  req_if,
   tqc_rsp_if.source rsp_if
);

   tqc_pkg::cell_data_type          cells [tqc_pkg::DEPTH];
   tqc_pkg::cell_ctl_type           ctl   [tqc_pkg::DEPTH];
   logic [tqc_pkg::TICKET_BITS-1:0] load_ticket;
   logic [tqc_pkg::PARTY_BITS-1:0]  load_party;
   tqc_pkg::result_type             result;
   tqc_pkg::result_type             rsp_data_ff, rsp_data_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept;

   // Take a new word whenever the result register is free or drains now.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   tqc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_if.command),
      .party_size  (req_if.party_size),
      .position    (req_if.position),
      .cells       (cells),
      .ctl         (ctl),
      .load_ticket (load_ticket),
      .load_party  (load_party),
      .result      (result)
   );

   // Cell 0 is the head; each cell looks at its neighbor toward the tail.
   // The last cell closes up from an empty slot.
   for (genvar i = 0; i < tqc_pkg::DEPTH; i++) begin : g_cell
      tqc_pkg::cell_data_type next_data;
      if (i == tqc_pkg::DEPTH - 1) begin : g_last
         assign next_data = '{valid: 1'b0, ticket: '0, party: '0};
      end else begin : g_mid
         assign next_data = cells[i+1];
      end
      tqc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[i]),
         .load_ticket (load_ticket),
         .load_party  (load_party),
         .next_data   (next_data),
         .cur_data    (cells[i])
      );
   end

   // Result register: load on accept, drop when taken, otherwise hold.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_data_ff.status;
   assign rsp_if.ticket    = rsp_data_ff.ticket;
   assign rsp_if.party_out = rsp_data_ff.party_out;
   assign rsp_if.occupancy = rsp_data_ff.occupancy;

endmodule

@@ design/tqc_checker.sv @@
// tqc_checker: port-level checks on the ticket queue, bound to the top level.
// Depends on tqc_pkg for codes and sizes.
module tqc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tqc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [tqc_pkg::TICKET_W-1:0]     rsp_ticket,
   input logic [tqc_pkg::PARTY_OUT_W-1:0]  rsp_party_out,
   input logic [tqc_pkg::OCC_W-1:0]        rsp_occupancy
);

   // A result word waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before taken");

   // Every accepted command word yields a result word in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result word after accepted command");

   // An error result carries no entry.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != tqc_pkg::ST_OK) |->
         (rsp_ticket == '0) && (rsp_party_out == '0))
      else $error("error result carries entry data");

   // Occupancy stays within the queue depth and matches full/empty reports.
   a_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_occupancy <= tqc_pkg::OCC_W'(tqc_pkg::DEPTH)) &&
         ((rsp_status != tqc_pkg::ST_FULL) ||
          (rsp_occupancy == tqc_pkg::OCC_W'(tqc_pkg::DEPTH))) &&
         ((rsp_status != tqc_pkg::ST_EMPTY) || (rsp_occupancy == '0)))
      else $error("occupancy inconsistent with status");

endmodule

bind ticket_queue_with_cancel_top tqc_checker u_tqc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_ticket    (rsp_if.ticket),
   .rsp_party_out (rsp_if.party_out),
   .rsp_occupancy (rsp_if.occupancy)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for ticket_queue_with_cancel_top, with a waitlist tracker
// that predicts every result word. Depends on tqc_pkg, tqc_ifs and the design top level.
module testbench;

   // Mirror of the waiting queue: predicts one result word per accepted command word
   // and holds the predictions until the block returns them.
   class waitlist_tracker;
      logic [tqc_pkg::TICKET_BITS-1:0] slot_ticket[tqc_pkg::DEPTH];
      logic [tqc_pkg::PARTY_BITS-1:0]  slot_party[tqc_pkg::DEPTH];
      int                              occupied;
      tqc_pkg::result_type             due_results[$];
      int                              mismatches;

      function new();
         occupied   = 0;
         mismatches = 0;
      endfunction

      // Pull out the entry at idx and close up everything behind it.
      function void take_slot(int idx, output logic [tqc_pkg::TICKET_W-1:0] tk,
                              output logic [tqc_pkg::PARTY_OUT_W-1:0] pt);
         tk = slot_ticket[idx];
         pt = slot_party[idx];
         for (int i = idx; i + 1 < occupied; i++) begin
            slot_ticket[i] = slot_ticket[i+1];
            slot_party[i]  = slot_party[i+1];
         end
         occupied--;
      endfunction

      function void book_command(tqc_pkg::cmd_type cmd,
                                 logic [tqc_pkg::PARTY_IN_W-1:0] psize,
                                 logic [tqc_pkg::POS_W-1:0] pos);
         tqc_pkg::result_type             r;
         logic [tqc_pkg::TICKET_BITS-1:0] next_ticket;
         r.status    = tqc_pkg::ST_OK;
         r.ticket    = '0;
         r.party_out = '0;
         case (cmd)
            tqc_pkg::CMD_ENQUEUE: begin
               if (occupied >= tqc_pkg::DEPTH) begin
                  r.status = tqc_pkg::ST_FULL;
               end else begin
                  next_ticket = (occupied == 0) ? tqc_pkg::TICKET_BITS'(1)
                                                : slot_ticket[occupied-1] + 1'b1;
                  slot_ticket[occupied] = next_ticket;
                  slot_party[occupied]  = psize[tqc_pkg::PARTY_BITS-1:0];
                  r.ticket    = next_ticket;
                  r.party_out = psize[tqc_pkg::PARTY_BITS-1:0];
                  occupied++;
               end
            end
            tqc_pkg::CMD_DEQUEUE: begin
               if (occupied == 0) r.status = tqc_pkg::ST_EMPTY;
               else take_slot(0, r.ticket, r.party_out);
            end
            tqc_pkg::CMD_CANCEL: begin
               if (pos == 0 || pos > occupied) r.status = tqc_pkg::ST_NOPOS;
               else take_slot(pos - 1, r.ticket, r.party_out);
            end
            default: ;
         endcase
         r.occupancy = tqc_pkg::OCC_W'(occupied);
         due_results.push_back(r);
      endfunction

      function void report(string what, tqc_pkg::result_type want,
                           tqc_pkg::result_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%0t %s: want st %0d tk %0d pt %0d occ %0d,",
                      " got st %0d tk %0d pt %0d occ %0d"},
                     $realtime, what, want.status, want.ticket, want.party_out,
                     want.occupancy, got.status, got.ticket, got.party_out,
                     got.occupancy);
      endfunction

      function void match_result(tqc_pkg::result_type got);
         tqc_pkg::result_type want;
         if (due_results.size() == 0) begin
            report("unexpected result word", '0, got);
         end else begin
            want = due_results.pop_front();
            if (got.status !== want.status || got.ticket !== want.ticket ||
                got.party_out !== want.party_out || got.occupancy !== want.occupancy)
               report("result word differs", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   calm = 0;   // when set, neither side idles

   tqc_req_if req_ch ();
   tqc_rsp_if rsp_ch ();

   waitlist_tracker board = new();

   ticket_queue_with_cancel_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check each accepted word against the oldest prediction, then pick
   // the ready level for the next cycle. Values read here are the ones at the edge.
   always @(posedge clock) begin : result_sink
      tqc_pkg::result_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.status    = tqc_pkg::status_type'(rsp_ch.status);
         seen.ticket    = rsp_ch.ticket;
         seen.party_out = rsp_ch.party_out;
         seen.occupancy = rsp_ch.occupancy;
         board.match_result(seen);
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   // Offer one command word, idling first at random, and hold it until accepted.
   // Book the prediction at the accept edge, before the next word is chosen, so the
   // tracker's occupancy is always current for picking cancel positions.
   task automatic send_word(tqc_pkg::cmd_type cmd, logic [tqc_pkg::PARTY_IN_W-1:0] psize,
                            logic [tqc_pkg::POS_W-1:0] pos);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.party_size <= psize;
      req_ch.position   <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.book_command(cmd, psize, pos);
   endtask

   // Drop valid and hold off until every predicted word has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int enq_weight;
      int roll;
      logic [tqc_pkg::POS_W-1:0] pick_pos;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= tqc_pkg::CMD_ENQUEUE;
      req_ch.party_size <= '0;
      req_ch.position   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: errors on an empty queue, the ignored command, field extremes.
      send_word(tqc_pkg::CMD_DEQUEUE, 8'hff, 5'd0);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd1);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd0);
      send_word(tqc_pkg::CMD_NOP, 8'hff, 5'd31);
      send_word(tqc_pkg::CMD_ENQUEUE, 8'h00, 5'd31);
      send_word(tqc_pkg::CMD_ENQUEUE, 8'hff, 5'd0);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd0);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd3);
      send_word(tqc_pkg::CMD_CANCEL, 8'hff, 5'd31);
      send_word(tqc_pkg::CMD_NOP, 8'h00, 5'd0);
      // Fill to the top, then knock on a full queue.
      while (board.occupied < tqc_pkg::DEPTH)
         send_word(tqc_pkg::CMD_ENQUEUE,
                   tqc_pkg::PARTY_IN_W'($urandom_range(0, 255)), 5'd0);
      send_word(tqc_pkg::CMD_ENQUEUE, 8'h5a, 5'd0);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd17);
      // Cancel the tail; the next enqueue must follow the new tail ticket.
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd16);
      send_word(tqc_pkg::CMD_ENQUEUE, 8'ha5, 5'd0);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd8);
      send_word(tqc_pkg::CMD_CANCEL, 8'h00, 5'd1);
      send_word(tqc_pkg::CMD_DEQUEUE, 8'h00, 5'd0);

      // Pause the sender until the block has answered everything.
      wait_drained();

      // Random: blocks with varying enqueue weight sweep the fill level from
      // empty to full; most cancels hit a live position, the rest any position.
      sent = 0;
      enq_weight = 50;
      while (sent < 1000) begin
         if (sent % 64 == 0) enq_weight = 15 + 20 * $urandom_range(0, 3);
         calm = (sent >= 400 && sent < 600);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_word(tqc_pkg::CMD_NOP, tqc_pkg::PARTY_IN_W'($urandom_range(0, 255)),
                      tqc_pkg::POS_W'($urandom_range(0, 31)));
         end else if (roll < 4 + enq_weight) begin
            send_word(tqc_pkg::CMD_ENQUEUE, tqc_pkg::PARTY_IN_W'($urandom_range(0, 255)),
                      tqc_pkg::POS_W'($urandom_range(0, 31)));
            sent++;
         end else if ($urandom_range(0, 1) == 0) begin
            send_word(tqc_pkg::CMD_DEQUEUE, tqc_pkg::PARTY_IN_W'($urandom_range(0, 255)),
                      tqc_pkg::POS_W'($urandom_range(0, 31)));
            sent++;
         end else begin
            if (board.occupied > 0 && $urandom_range(0, 99) < 85)
               pick_pos = tqc_pkg::POS_W'($urandom_range(1, board.occupied));
            else
               pick_pos = tqc_pkg::POS_W'($urandom_range(0, 31));
            send_word(tqc_pkg::CMD_CANCEL, tqc_pkg::PARTY_IN_W'($urandom_range(0, 255)),
                      pick_pos);
            sent++;
         end
      end
      calm = 0;

      // Drain, let the pipe settle, then judge.
      wait_drained();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(20_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
